>>> rtl/psrl2d_pkg.sv
`default_nettype none

package psrl2d_pkg;

    // Line store depth and derived widths
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CHAN_W    = 16;
    localparam int NUM_CHAN  = 4;
    localparam int PIX_W     = CHAN_W * NUM_CHAN;
    localparam int WIDTH_W   = 13;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    // compare width for column + 1 against the effective width
    localparam int CMPW_W    = ((COL_W + 1) > WIDTH_W) ? (COL_W + 1) : WIDTH_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RISE_H = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_V = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_V = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic             first_col;
        logic             first_row;
    } psrl2d_item_t;

    // Slew rates used by the back end
    typedef struct packed {
        logic [CHAN_W-1:0] rise_h;
        logic [CHAN_W-1:0] fall_h;
        logic [CHAN_W-1:0] rise_v;
        logic [CHAN_W-1:0] fall_v;
    } psrl2d_rates_t;

endpackage

`default_nettype wire

>>> rtl/psrl2d_front.sv
`default_nettype none

// Accepts pixels, tracks raster position and tags each word with its column
// and first-row / first-column flags.
module psrl2d_front
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [psrl2d_pkg::PIX_W-1:0]     s_tdata,
    input  wire logic [psrl2d_pkg::WIDTH_W-1:0]   image_width,
    input  wire logic [psrl2d_pkg::HEIGHT_W-1:0]  image_height,
    input  wire logic                             q_ready,
    output logic                                  q_push,
    output psrl2d_pkg::psrl2d_item_t              q_item
);

    logic [psrl2d_pkg::COL_W-1:0]    col_reg;
    logic [psrl2d_pkg::COL_W-1:0]    col_next;
    logic [psrl2d_pkg::HEIGHT_W-1:0] row_reg;
    logic [psrl2d_pkg::HEIGHT_W-1:0] row_next;
    logic [psrl2d_pkg::CMPW_W-1:0]   w_eff;
    logic [psrl2d_pkg::CMPW_W-1:0]   col_inc;
    logic [psrl2d_pkg::HEIGHT_W:0]   h_eff;
    logic [psrl2d_pkg::HEIGHT_W:0]   row_inc;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb
    begin
        q_item.pixel     = s_tdata;
        q_item.col       = col_reg;
        q_item.first_col = (col_reg == '0);
        q_item.first_row = (row_reg == '0);
    end

    // Effective frame size: zero acts as one, width capped at the store depth
    always_comb
    begin
        if (image_width == '0)
        begin
            w_eff = psrl2d_pkg::CMPW_W'(1);
        end
        else if (psrl2d_pkg::CMPW_W'(image_width) > psrl2d_pkg::CMPW_W'(psrl2d_pkg::MAX_WIDTH))
        begin
            w_eff = psrl2d_pkg::CMPW_W'(psrl2d_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = psrl2d_pkg::CMPW_W'(image_width);
        end
        if (image_height == '0)
        begin
            h_eff = (psrl2d_pkg::HEIGHT_W+1)'(1);
        end
        else
        begin
            h_eff = {1'b0, image_height};
        end
    end

    always_comb
    begin
        col_inc  = psrl2d_pkg::CMPW_W'(col_reg) + psrl2d_pkg::CMPW_W'(1);
        row_inc  = {1'b0, row_reg} + (psrl2d_pkg::HEIGHT_W+1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[psrl2d_pkg::HEIGHT_W-1:0];
            end
            else
            begin
                col_next = col_inc[psrl2d_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/psrl2d_queue.sv
`default_nettype none

// Two-entry queue between front and back.
module psrl2d_queue
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire psrl2d_pkg::psrl2d_item_t  push_item,
    output logic                           push_ready,
    input  wire logic                      pop,
    output logic                           pop_valid,
    output psrl2d_pkg::psrl2d_item_t       pop_item
);

    psrl2d_pkg::psrl2d_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/psrl2d_back.sv
`default_nettype none

// Line store read, left/above clamps and output register.
module psrl2d_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire psrl2d_pkg::psrl2d_rates_t     rates,
    input  wire logic                          q_valid,
    input  wire psrl2d_pkg::psrl2d_item_t      q_item,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [psrl2d_pkg::PIX_W-1:0]       m_tdata
);

    localparam int CW = psrl2d_pkg::CHAN_W;

    logic [psrl2d_pkg::PIX_W-1:0] line_mem [psrl2d_pkg::MAX_WIDTH];

    logic                         a_valid_reg;
    psrl2d_pkg::psrl2d_item_t     a_item_reg;
    logic [psrl2d_pkg::PIX_W-1:0] above_reg;
    logic [psrl2d_pkg::PIX_W-1:0] left_reg;
    logic                         out_valid_reg;
    logic [psrl2d_pkg::PIX_W-1:0] out_data_reg;
    logic                         a_adv;
    logic [psrl2d_pkg::PIX_W-1:0] result;

    // Clamp v into [base - fall, base + rise]
    function automatic logic [CW-1:0] clamp_chan(
        input logic [CW-1:0] v,
        input logic [CW-1:0] base,
        input logic [CW-1:0] rise,
        input logic [CW-1:0] fall
    );
        logic signed [CW+1:0] lo;
        logic signed [CW+1:0] hi;
        logic signed [CW+1:0] x;
        lo = signed'({2'b00, base}) - signed'({2'b00, fall});
        hi = signed'({2'b00, base}) + signed'({2'b00, rise});
        x  = signed'({2'b00, v});
        if (x < lo)
        begin
            x = lo;
        end
        if (x > hi)
        begin
            x = hi;
        end
        return x[CW-1:0];
    endfunction

    assign a_adv    = a_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop    = q_valid && (!a_valid_reg || a_adv);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        for (int c = 0; c < psrl2d_pkg::NUM_CHAN; c++)
        begin
            logic [CW-1:0] v;
            v = a_item_reg.pixel[c*CW +: CW];
            if (!a_item_reg.first_col)
            begin
                v = clamp_chan(v, left_reg[c*CW +: CW], rates.rise_h, rates.fall_h);
            end
            if (!a_item_reg.first_row)
            begin
                v = clamp_chan(v, above_reg[c*CW +: CW], rates.rise_v, rates.fall_v);
            end
            result[c*CW +: CW] = v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= result;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_item_reg <= q_item;
        end
        if (a_adv)
        begin
            out_data_reg <= result;
        end
    end

    // Line store; a read of the column being written this cycle takes the new word
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            line_mem[a_item_reg.col] <= result;
        end
        if (q_pop)
        begin
            if (a_adv && (a_item_reg.col == q_item.col))
            begin
                above_reg <= result;
            end
            else
            begin
                above_reg <= line_mem[q_item.col];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pixel_slew_rate_limiter_2d_unit.sv
// Two-dimensional slew rate limiter for RGBA pixels, 16 bits per channel.
// Slave stream s_*: one pixel per word in raster order, red in the low bits.
// Master stream m_*: the limited pixel, same packing, one word per input.
// Config port cfg_*: index 0..5 = rise_h, fall_h, rise_v, fall_v, width,
// height; other indexes are ignored; cfg_ready is always high. Write only
// while no pixel is in flight.
// Each channel is clamped to [left - fall_h, left + rise_h] outside the first
// column, then to [above - fall_v, above + rise_v] outside the first row.
// An accepted pixel passes through the queue, then the line store read into
// the clamp stage, then the clamp into the output register. While m_tready is
// high the block takes one pixel per cycle; the rate is set by the loop
// through the clamp and the left-pixel register.
// A 2-word queue separates the counter front end from the clamp back end, and
// the output register lets the next pixel be taken while a result waits.
// When m_tready is low the output holds, the clamp stage and queue fill, and
// s_tready drops after at most 4 words are inside.
// Reset (rst_n low, async): counters and left pixel cleared, rates to 65535,
// width 4096, height 65535, no word in flight. The line store is not cleared;
// rows after the first read only entries written earlier in the frame.
`default_nettype none

module pixel_slew_rate_limiter_2d_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // red_in[15:0], green_in[31:16], blue_in[47:32], alpha_in[63:48]
    input  wire logic [psrl2d_pkg::PIX_W-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32], alpha_out[63:48]
    output logic [psrl2d_pkg::PIX_W-1:0]            m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [psrl2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [psrl2d_pkg::CFG_DAT_W-1:0]   cfg_data
);

    logic [psrl2d_pkg::CHAN_W-1:0]   rise_h_reg;
    logic [psrl2d_pkg::CHAN_W-1:0]   fall_h_reg;
    logic [psrl2d_pkg::CHAN_W-1:0]   rise_v_reg;
    logic [psrl2d_pkg::CHAN_W-1:0]   fall_v_reg;
    logic [psrl2d_pkg::WIDTH_W-1:0]  width_reg;
    logic [psrl2d_pkg::HEIGHT_W-1:0] height_reg;
    psrl2d_pkg::psrl2d_rates_t       rates;

    logic                            q_push;
    logic                            q_ready;
    psrl2d_pkg::psrl2d_item_t        push_item;
    logic                            q_pop;
    logic                            q_valid;
    psrl2d_pkg::psrl2d_item_t        pop_item;

    // words accepted but not yet delivered
    logic [2:0]                      inflight_reg;
    logic [2:0]                      inflight_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_h_reg <= '1;
            fall_h_reg <= '1;
            rise_v_reg <= '1;
            fall_v_reg <= '1;
            width_reg  <= psrl2d_pkg::WIDTH_W'(psrl2d_pkg::MAX_WIDTH);
            height_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psrl2d_pkg::REG_RISE_H: rise_h_reg <= cfg_data;
                psrl2d_pkg::REG_FALL_H: fall_h_reg <= cfg_data;
                psrl2d_pkg::REG_RISE_V: rise_v_reg <= cfg_data;
                psrl2d_pkg::REG_FALL_V: fall_v_reg <= cfg_data;
                psrl2d_pkg::REG_WIDTH:  width_reg  <= cfg_data[psrl2d_pkg::WIDTH_W-1:0];
                psrl2d_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        rates.rise_h = rise_h_reg;
        rates.fall_h = fall_h_reg;
        rates.rise_v = rise_v_reg;
        rates.fall_v = fall_v_reg;
    end

    psrl2d_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    psrl2d_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (pop_item)
    );

    psrl2d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rates    (rates),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // In-flight count for checks: queue (2) + clamp stage (1) + output (1)
    always_comb
    begin
        inflight_next = inflight_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready))
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more words inside than storage allows");

    a_no_phantom_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (inflight_reg != 3'd0))
        else $error("output valid with no word in flight");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 3'd0) |-> s_tready)
        else $error("input stalled while block is empty");

endmodule

`default_nettype wire
